// File: design/msp_gate_pkg.sv
// shared widths, codes and defaults for the sighting push gate
// no dependencies; imported by mac_sighting_push_gate_unit
package msp_gate_pkg;

  // field widths
  localparam int MAC_W   = 48;
  localparam int ROLE_W  = 2;
  localparam int MODEL_W = 5;
  localparam int TIME_W  = 64;

  // role codes
  localparam logic [ROLE_W-1:0] ROLE_UNKNOWN = 2'd0;
  localparam logic [ROLE_W-1:0] ROLE_BOX     = 2'd1;
  localparam logic [ROLE_W-1:0] ROLE_MASTER  = 2'd2;

  // stored code for an unidentified model
  localparam logic [MODEL_W-1:0] MODEL_NONE = '1;

  // parameter defaults
  localparam int TABLE_DEPTH_DEF = 32;
  localparam int MODEL_COUNT_DEF = 16;

  // refresh window after reset
  localparam logic [TIME_W-1:0] REFRESH_RESET = 64'd1000000000;

endpackage

// File: design/mac_sighting_push_gate_unit.sv
// Sequence: SCAN compares each entry read against the latched mac; a new or dropped mac goes
// straight to DONE, a match with an edge passes CHECK then DONE, and a refresh check passes CHECK,
// EVAL and DONE; the scan reads one table entry per cycle from a single read port.
// Throughput: one sighting at a time; the next input transfer waits until the result is loaded
// and the sequencer is back in idle; a stalled result holds it.
// Reset: rst (synchronous) empties the table (fill count zero), clears the result channel,
// sets refresh_window to 1000000000 and holds off both input channels; contents not cleared.
module mac_sighting_push_gate_unit #(
  parameter int TABLE_DEPTH = msp_gate_pkg::TABLE_DEPTH_DEF,
  parameter int MODEL_COUNT = msp_gate_pkg::MODEL_COUNT_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  // configuration write channel
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [msp_gate_pkg::TIME_W-1:0]          cfg_data,
  // sighting input channel
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic [msp_gate_pkg::MAC_W-1:0]           mac,
  input  logic [msp_gate_pkg::ROLE_W-1:0]          role,
  input  logic signed [msp_gate_pkg::MODEL_W-1:0]  model_index,
  input  logic [msp_gate_pkg::TIME_W-1:0]          now,
  // result channel
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic                                     push_res
);
  import msp_gate_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_EVAL  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]         state;
  logic [TIME_W-1:0]  refresh_window;
  logic [CNT_W-1:0]   entry_count;

  // latched sighting, normalized
  logic [MAC_W-1:0]   mac_q;
  logic [ROLE_W-1:0]  role_q;
  logic [MODEL_W-1:0] model_q;
  logic               model_known_q;
  logic [TIME_W-1:0]  now_q;

  // scan pointer and registered read data
  logic [CNT_W-1:0]   addr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic [MAC_W-1:0]   rd_mac;
  logic [ROLE_W-1:0]  rd_role;
  logic [MODEL_W-1:0] rd_model;
  logic [TIME_W-1:0]  rd_last;

  // refresh check
  logic               back;
  logic [TIME_W-1:0]  diff;
  logic               push;

  // table storage
  logic [MAC_W-1:0]   entry_mac       [TABLE_DEPTH];
  logic [ROLE_W-1:0]  entry_role      [TABLE_DEPTH];
  logic [MODEL_W-1:0] entry_model     [TABLE_DEPTH];
  logic [TIME_W-1:0]  entry_last_push [TABLE_DEPTH];

  // combinational control
  logic               in_xfer;
  logic               out_xfer;
  logic               rd_en;
  logic               hit;
  logic               miss;
  logic               full;
  logic               role_edge;
  logic               model_edge;
  logic               in_role_known;
  logic               in_model_known;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [MAC_W-1:0]   wmac;
  logic [ROLE_W-1:0]  wrole;
  logic [MODEL_W-1:0] wmodel;
  logic [TIME_W-1:0]  wlast;

  assign cfg_ready = !rst;
  assign in_stall  = rst || (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid && !out_stall;

  // input normalization: role three is unknown, out-of-range model is unidentified
  assign in_role_known  = (role == ROLE_BOX) || (role == ROLE_MASTER);
  assign in_model_known = !model_index[MODEL_W-1] &&
                          (int'(model_index[MODEL_W-2:0]) < MODEL_COUNT);

  // scan step: issue a read while entries remain, compare the one read last cycle
  assign rd_en = (state == ST_SCAN) && (addr < entry_count) && !hit;
  assign hit   = (state == ST_SCAN) && rd_vld && (rd_mac == mac_q);
  assign miss  = (state == ST_SCAN) && !hit && (addr >= entry_count);
  assign full  = (entry_count >= DEPTH_CNT);

  // edge detection against the matched entry
  assign role_edge  = (role_q != ROLE_UNKNOWN) && (role_q != rd_role);
  assign model_edge = model_known_q && (model_q != rd_model);

  // table write port
  always_comb begin
    we     = 1'b0;
    waddr  = rd_idx;
    wmac   = rd_mac;
    wrole  = (role_q != ROLE_UNKNOWN) ? role_q : rd_role;
    wmodel = model_known_q ? model_q : rd_model;
    wlast  = now_q;
    case (state)
      ST_SCAN: begin
        if (miss && !full) begin
          we     = 1'b1;
          waddr  = entry_count[IDX_W-1:0];
          wmac   = mac_q;
          wrole  = role_q;
          wmodel = model_q;
        end
      end
      ST_CHECK: begin
        we = role_edge || model_edge;
      end
      ST_EVAL: begin
        we = back || (diff >= refresh_window);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      entry_mac[waddr]       <= wmac;
      entry_role[waddr]      <= wrole;
      entry_model[waddr]     <= wmodel;
      entry_last_push[waddr] <= wlast;
    end
    if (rd_en) begin
      rd_mac   <= entry_mac[addr[IDX_W-1:0]];
      rd_role  <= entry_role[addr[IDX_W-1:0]];
      rd_model <= entry_model[addr[IDX_W-1:0]];
      rd_last  <= entry_last_push[addr[IDX_W-1:0]];
      rd_idx   <= addr[IDX_W-1:0];
    end
  end

  // latch the sighting on input transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mac_q         <= mac;
      role_q        <= in_role_known ? role : ROLE_UNKNOWN;
      model_q       <= in_model_known ? model_index : MODEL_NONE;
      model_known_q <= in_model_known;
      now_q         <= now;
    end
    if (state == ST_CHECK) begin
      back <= (now_q < rd_last);
      diff <= now_q - rd_last;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_window <= REFRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      refresh_window <= cfg_data;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      entry_count <= '0;
      addr        <= '0;
      rd_vld      <= 1'b0;
      push        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            addr   <= '0;
            rd_vld <= 1'b0;
            state  <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          rd_vld <= rd_en;
          if (rd_en) begin
            addr <= addr + 1'b1;
          end
          if (hit) begin
            state <= ST_CHECK;
          end else if (miss) begin
            push <= !full;
            if (!full) begin
              entry_count <= entry_count + 1'b1;
            end
            state <= ST_DONE;
          end
        end
        ST_CHECK: begin
          if (role_edge || model_edge) begin
            push  <= 1'b1;
            state <= ST_DONE;
          end else begin
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          push  <= back || (diff >= refresh_window);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && (!out_valid || !out_stall)) begin
      push_res <= push;
    end
  end

endmodule
